// ===== rtl/gift_wrapping_convex_hull_top_defines.svh =====
// assertion macros for the convex hull block
// used by the checker module only
`ifndef GIFT_WRAPPING_CONVEX_HULL_TOP_DEFINES_SVH
`define GIFT_WRAPPING_CONVEX_HULL_TOP_DEFINES_SVH

// implication checked on every edge outside reset
`define GWCH_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication with the consequent checked in the next cycle
`define GWCH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gwch_pkg.sv =====
// package for the convex hull block: sizes and state codes
// no dependencies
package gwch_pkg;
  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int MIN_HULL = 3;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FEW,
    ST_MIN_RD,
    ST_MIN_CHK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_START_CHK,
    ST_EMIT,
    ST_MARK_RD,
    ST_MARK_CHK,
    ST_WAIT
  } state_t;
endpackage

// ===== rtl/gwch_ram.sv =====
// generic single-port synchronous ram, registered read
// no dependencies
module gwch_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/gift_wrapping_convex_hull_top.sv =====
// convex hull by gift wrapping over a stored point set
// uses gwch_pkg and gwch_ram (one ram holds x, y and the taken mark of every point)
//
// Usage: points enter on the s_axis channel, one item per cycle while
// loading, x in tdata[15:0] and y in tdata[31:16]; s_axis_tlast marks the
// final point of a set. Only the result of a set with too few points can
// leave during loading. After the final point the block finds the lowest
// point, then wraps: each hull step reads all n stored points through one
// ram port, a read and then the compare against the running best for each
// point, then marks every copy of the chosen point taken in the ram in a
// second pass over all stored points.
// Results leave on m_axis: x, y in tdata, last in tlast, and in tuser
// too_few (bit 0) and dropped (bit 1). The block holds each result until
// m_axis_tready; a stalled receiver freezes the walk. s_axis_tready is low
// from the final point until the last result of the set is taken; a set
// with too few points goes back to loading once its result is queued.
// Reset clears the state, count, overflow and output valid; the taken mark
// is written clear with each point, so the ram needs no clearing pass.
module gift_wrapping_convex_hull_top #(
  parameter int MAX_POINTS = gwch_pkg::MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // in_x [15:0], in_y [31:16]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // hull_x [15:0], hull_y [31:16]
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser    // too_few [0], dropped [1]
);
  import gwch_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int CB = COORD_BITS_DEF;
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW + 1;

  state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic          overflow, overflow_next;
  logic [AW-1:0] idx, idx_next;
  logic [CW-1:0] steps, steps_next;
  logic          first, first_next;
  logic          have, have_next;
  logic signed [CB-1:0] sx, sy, sx_next, sy_next;
  logic signed [CB-1:0] cx, cy, cx_next, cy_next;
  logic signed [CB-1:0] bx, by, bx_next, by_next;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [2*CB:0] ram_wdata, ram_rdata;

  logic signed [CB-1:0] ox, oy, ox_next, oy_next;
  logic olast, olast_next, ofew, ofew_next, odrop, odrop_next, ovalid, ovalid_next;

  gwch_ram #(.WIDTH(2 * CB + 1), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  logic signed [CB-1:0] rx, ry;
  logic rtaken;
  assign rx = ram_rdata[CB-1:0];
  assign ry = ram_rdata[2*CB-1:CB];
  assign rtaken = ram_rdata[2*CB];

  // candidate point for compare: ram data or the start point
  logic use_start;
  logic signed [CB-1:0] kx, ky;
  assign kx = use_start ? sx : rx;
  assign ky = use_start ? sy : ry;

  logic signed [DW-1:0] ax, ay, qx, qy;
  logic signed [PW-1:0] cr, da, db;
  assign ax = DW'(kx) - DW'(cx);
  assign ay = DW'(ky) - DW'(cy);
  assign qx = DW'(bx) - DW'(cx);
  assign qy = DW'(by) - DW'(cy);
  assign cr = PW'(ax) * PW'(qy) - PW'(ay) * PW'(qx);
  assign da = PW'(ax) * PW'(ax) + PW'(ay) * PW'(ay);
  assign db = PW'(qx) * PW'(qx) + PW'(qy) * PW'(qy);

  logic better;
  assign better = !have || (cr > 0) || (cr == 0 && $unsigned(da) > $unsigned(db));

  logic s_fire, m_fire, last_idx;
  logic [AW-1:0] prev_idx;
  logic [CW-1:0] count_m1;
  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign m_fire   = m_axis_tvalid && m_axis_tready;
  assign count_m1 = count - CW'(1);
  assign last_idx = (CW'(idx) == count_m1);
  // entry on rdata during the lowest-point search
  assign prev_idx = idx - AW'(1);
  assign s_axis_tready = (state == ST_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      overflow <= 1'b0;
      ovalid   <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      overflow <= overflow_next;
      ovalid   <= ovalid_next;
    end
    idx <= idx_next;  steps <= steps_next;  first <= first_next;  have <= have_next;
    sx <= sx_next;  sy <= sy_next;  cx <= cx_next;  cy <= cy_next;
    bx <= bx_next;  by <= by_next;
    ox <= ox_next;  oy <= oy_next;  olast <= olast_next;
    ofew <= ofew_next;  odrop <= odrop_next;
  end

  always_comb begin
    state_next = state;
    count_next = count;  overflow_next = overflow;
    idx_next = idx;  steps_next = steps;  first_next = first;  have_next = have;
    sx_next = sx;  sy_next = sy;  cx_next = cx;  cy_next = cy;
    bx_next = bx;  by_next = by;
    ox_next = ox;  oy_next = oy;  olast_next = olast;  ofew_next = ofew;
    odrop_next = odrop;
    ovalid_next = ovalid && !m_fire;
    ram_we = 1'b0;
    ram_addr = idx;
    ram_wdata = {1'b0, s_axis_tdata[16 +: CB], s_axis_tdata[0 +: CB]};
    use_start = 1'b0;
    unique case (state)
      ST_LOAD: begin
        ram_addr = count[AW-1:0];
        if (s_fire) begin
          if (count < CW'(MAX_POINTS)) begin
            ram_we = 1'b1;
            count_next = count + CW'(1);
          end else begin
            overflow_next = 1'b1;
          end
          if (s_axis_tlast) begin
            idx_next = '0;
            if (count < CW'(MAX_POINTS) && count + CW'(1) < CW'(MIN_HULL)) begin
              state_next = ST_FEW;
            end else begin
              state_next = ST_MIN_RD;
            end
          end
        end
      end
      ST_FEW: begin
        if (!ovalid) begin
          ox_next = '0;  oy_next = '0;  olast_next = 1'b1;  ofew_next = 1'b1;
          odrop_next = overflow;  ovalid_next = 1'b1;
          count_next = '0;  overflow_next = 1'b0;
          state_next = ST_LOAD;
        end
      end
      ST_MIN_RD: begin
        idx_next = idx + AW'(1);
        state_next = ST_MIN_CHK;
      end
      ST_MIN_CHK: begin
        // ram read of idx-1 is on rdata; address idx is issued now
        if (idx == AW'(1) || ry < sy || (ry == sy && rx < sx)) begin
          sx_next = rx;  sy_next = ry;
        end
        if (prev_idx == count_m1[AW-1:0]) begin
          state_next = ST_SCAN_RD;
          idx_next = '0;
          first_next = 1'b1;
          steps_next = '0;
          if (idx == AW'(1) || ry < sy || (ry == sy && rx < sx)) begin
            cx_next = rx;  cy_next = ry;
          end else begin
            cx_next = sx;  cy_next = sy;
          end
          have_next = 1'b0;
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      ST_SCAN_RD: begin
        state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (!rtaken && !(rx == sx && ry == sy) && better) begin
          bx_next = rx;  by_next = ry;  have_next = 1'b1;
        end
        if (last_idx) begin
          state_next = first ? ST_EMIT : ST_START_CHK;
        end else begin
          idx_next = idx + AW'(1);
          state_next = ST_SCAN_RD;
        end
      end
      ST_START_CHK: begin
        use_start = 1'b1;
        if (better) begin
          bx_next = sx;  by_next = sy;  have_next = 1'b1;
        end
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!ovalid) begin
          ofew_next = 1'b0;  odrop_next = overflow;  ovalid_next = 1'b1;
          first_next = 1'b0;
          steps_next = steps + CW'(1);
          if (!have || (bx == sx && by == sy)) begin
            ox_next = sx;  oy_next = sy;  olast_next = 1'b1;
            state_next = ST_WAIT;
          end else begin
            ox_next = bx;  oy_next = by;
            olast_next = (steps + CW'(1) == CW'(MAX_POINTS));
            cx_next = bx;  cy_next = by;
            idx_next = '0;
            state_next = (steps + CW'(1) == CW'(MAX_POINTS)) ? ST_WAIT : ST_MARK_RD;
          end
        end
      end
      ST_MARK_RD: begin
        state_next = ST_MARK_CHK;
      end
      ST_MARK_CHK: begin
        // write the entry back with its taken mark set if it is the chosen point
        if (rx == cx && ry == cy) begin
          ram_we = 1'b1;
          ram_wdata = {1'b1, ram_rdata[2*CB-1:0]};
        end
        if (last_idx) begin
          idx_next = '0;
          have_next = 1'b0;
          state_next = ST_SCAN_RD;
        end else begin
          idx_next = idx + AW'(1);
          state_next = ST_MARK_RD;
        end
      end
      ST_WAIT: begin
        if (!ovalid) begin
          count_next = '0;  overflow_next = 1'b0;
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata  = {16'(oy), 16'(ox)};
  assign m_axis_tlast  = olast;
  assign m_axis_tuser  = {odrop, ofew};
endmodule

// ===== rtl/gwch_checker.sv =====
// port-level checker for the convex hull block, bound to the top level
// uses gift_wrapping_convex_hull_top_defines.svh
`include "gift_wrapping_convex_hull_top_defines.svh"

module gwch_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [1:0]  m_axis_tuser
);
  `GWCH_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped under stall")
  `GWCH_ASSERT_IMPL(a_few_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast && m_axis_tdata == 32'd0, "too_few result malformed")
  `GWCH_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "input taken during hull")
  `GWCH_ASSERT_IMPL(a_no_out_load, m_axis_tvalid && s_axis_tready, m_axis_tlast, "result while loading")
endmodule

bind gift_wrapping_convex_hull_top gwch_checker u_gwch_checker (.*);
